// File: rtl/core/gdcq_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date query block.
`default_nettype none

package gdcq_pkg;

   // Reset value of the weekend mask: Friday and Saturday
   localparam logic [6:0] WEEKEND_MASK_RESET = 7'd96;

   // Weekday codes that the logic tests for
   localparam logic [2:0] WD_SATURDAY = 3'd6;

   // Month codes that the logic tests for
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // Year offset that keeps the weekday sum positive (400 years is whole weeks)
   localparam logic [14:0] YEAR_BASE = 15'd400;

   // Reciprocal of 100, exact for operands below 2^15
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int         SHIFT_100 = 19;

   // Reciprocal of 7, exact for operands below 2^15
   localparam logic [16:0] RECIP_7 = 17'd74899;
   localparam int          SHIFT_7 = 19;

   // Results of the calendar rules for one date
   typedef struct packed {
      logic        date_valid;
      logic [4:0]  days_to_month_end;
      logic [8:0]  days_to_year_end;
      logic [4:0]  next_day;
      logic [3:0]  next_month;
      logic [13:0] next_year;
   } gdcq_date_type;

   // Length of a month in a common year; zero for codes that are not months
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in a common year before the first of the month
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] cnt;
      unique case (month)
         4'd1:    cnt = 9'd0;
         4'd2:    cnt = 9'd31;
         4'd3:    cnt = 9'd59;
         4'd4:    cnt = 9'd90;
         4'd5:    cnt = 9'd120;
         4'd6:    cnt = 9'd151;
         4'd7:    cnt = 9'd181;
         4'd8:    cnt = 9'd212;
         4'd9:    cnt = 9'd243;
         4'd10:   cnt = 9'd273;
         4'd11:   cnt = 9'd304;
         4'd12:   cnt = 9'd334;
         default: cnt = 9'd0;
      endcase
      return cnt;
   endfunction

   // Month term of the weekday rule: floor(31 * shifted month / 12)
   function automatic logic [4:0] month_offset(input logic [3:0] month);
      logic [4:0] ofs;
      unique case (month)
         4'd1:    ofs = 5'd28;
         4'd2:    ofs = 5'd31;
         4'd3:    ofs = 5'd2;
         4'd4:    ofs = 5'd5;
         4'd5:    ofs = 5'd7;
         4'd6:    ofs = 5'd10;
         4'd7:    ofs = 5'd12;
         4'd8:    ofs = 5'd15;
         4'd9:    ofs = 5'd18;
         4'd10:   ofs = 5'd20;
         4'd11:   ofs = 5'd23;
         4'd12:   ofs = 5'd25;
         default: ofs = 5'd0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gdcq_date_rules.sv
// Month length, date check, remaining-day counts and following date for one date.
`default_nettype none

module gdcq_date_rules (
   input  wire logic [4:0]          day,
   input  wire logic [3:0]          month,
   input  wire logic [13:0]         year,
   input  wire logic                leap,
   output gdcq_pkg::gdcq_date_type  rules
);

   logic [4:0]  mlen;
   logic [8:0]  doy;
   logic [9:0]  ylen_plus;
   logic [9:0]  year_left;
   logic [4:0]  month_left;

   // Add the leap day to February
   always_comb begin
      mlen = gdcq_pkg::month_len(month);
      if (month == gdcq_pkg::MONTH_FEB && leap) begin
         mlen = 5'd29;
      end
   end

   // Day of year, leap day counted after February
   assign doy = gdcq_pkg::days_before(month) + 9'(day)
              + ((leap && month > gdcq_pkg::MONTH_FEB) ? 9'd1 : 9'd0);

   assign ylen_plus  = leap ? 10'd367 : 10'd366;
   assign year_left  = ylen_plus - 10'(doy);
   assign month_left = mlen - day + 5'd1;

   // Check the date and step to the following one
   always_comb begin
      rules.date_valid        = (mlen != 5'd0) && (day != 5'd0) && (day <= mlen);
      rules.days_to_month_end = month_left;
      rules.days_to_year_end  = year_left[8:0];
      if (day == mlen) begin
         rules.next_day = 5'd1;
         if (month == gdcq_pkg::MONTH_DEC) begin
            rules.next_month = gdcq_pkg::MONTH_JAN;
            rules.next_year  = year + 14'd1;
         end else begin
            rules.next_month = month + 4'd1;
            rules.next_year  = year;
         end
      end else begin
         rules.next_day   = day + 5'd1;
         rules.next_month = month;
         rules.next_year  = year;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gregorian_date_calendar_query.sv
// Gregorian date query: weekday, week/month/year position and following date.
// Five register stages (s1 to s4, rsp) lead to the rsp_ ports; each can hold an item.
// Throughput: one item per cycle while rsp_stall is low.
// A stalled result blocks only the stages behind it that are full.
// Reset (synchronous) empties all stages and sets the weekend mask to Friday/Saturday.
`default_nettype none

module gregorian_date_calendar_query (
   input  wire logic        clock,
   input  wire logic        reset,
   // date in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_day,
   input  wire logic [3:0]  req_month,
   input  wire logic [13:0] req_year,
   // result out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_weekday,
   output logic             rsp_end_of_week,
   output logic             rsp_weekend_flag,
   output logic             rsp_business_day,
   output logic [2:0]       rsp_days_to_week_end,
   output logic [4:0]       rsp_days_to_month_end,
   output logic [8:0]       rsp_days_to_year_end,
   output logic [4:0]       rsp_next_day,
   output logic [3:0]       rsp_next_month,
   output logic [13:0]      rsp_next_year,
   output logic             rsp_leap_flag,
   output logic             rsp_date_invalid,
   // weekend mask write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_weekend_mask
);

   // ---------------- stage control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, rsp_valid_in;
   logic s1_ready, s2_ready, s3_ready, s4_ready, rsp_ready;
   logic [6:0] weekend_mask_ff, weekend_mask_in;

   // A stage may load when it is empty or its item moves on
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req_stall = !s1_ready;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = s1_ready  ? req_valid    : s1_valid_ff;
   assign s2_valid_in  = s2_ready  ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in  = s3_ready  ? s2_valid_ff  : s3_valid_ff;
   assign s4_valid_in  = s4_ready  ? s3_valid_ff  : s4_valid_ff;
   assign rsp_valid_in = rsp_ready ? s4_valid_ff  : rsp_valid_ff;

   assign weekend_mask_in = csr_valid ? csr_weekend_mask : weekend_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         weekend_mask_ff <= gdcq_pkg::WEEKEND_MASK_RESET;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         s3_valid_ff     <= s3_valid_in;
         s4_valid_ff     <= s4_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         weekend_mask_ff <= weekend_mask_in;
      end
   end

   // ---------------- stage 1: capture the date ----------------
   logic [4:0]  s1_day_ff;
   logic [3:0]  s1_month_ff;
   logic [13:0] s1_year_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_day_ff   <= req_day;
         s1_month_ff <= req_month;
         s1_year_ff  <= req_year;
      end
   end

   // ---------------- stage 2: shifted year and hundreds ----------------
   logic        s2_jan_feb;
   logic [14:0] s2_yy_in;
   logic [26:0] s2_prod_y, s2_prod_yy;
   logic [7:0]  s2_cent_y_in, s2_cent_yy_in;
   logic [4:0]  s2_day_ff;
   logic [3:0]  s2_month_ff;
   logic [13:0] s2_year_ff;
   logic [14:0] s2_yy_ff;
   logic [7:0]  s2_cent_y_ff, s2_cent_yy_ff;

   // January and February count as months of the year before
   assign s2_jan_feb = (s1_month_ff == gdcq_pkg::MONTH_JAN)
                    || (s1_month_ff == gdcq_pkg::MONTH_FEB);
   assign s2_yy_in   = 15'(s1_year_ff) + gdcq_pkg::YEAR_BASE - (s2_jan_feb ? 15'd1 : 15'd0);

   // Divide both years by 100 through the reciprocal
   assign s2_prod_y     = 27'(s1_year_ff) * 27'(gdcq_pkg::RECIP_100);
   assign s2_prod_yy    = 27'(s2_yy_in) * 27'(gdcq_pkg::RECIP_100);
   assign s2_cent_y_in  = s2_prod_y[gdcq_pkg::SHIFT_100 +: 8];
   assign s2_cent_yy_in = s2_prod_yy[gdcq_pkg::SHIFT_100 +: 8];

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_day_ff     <= s1_day_ff;
         s2_month_ff   <= s1_month_ff;
         s2_year_ff    <= s1_year_ff;
         s2_yy_ff      <= s2_yy_in;
         s2_cent_y_ff  <= s2_cent_y_in;
         s2_cent_yy_ff <= s2_cent_yy_in;
      end
   end

   // ---------------- stage 3: leap rule and weekday sum ----------------
   logic [13:0] s3_rem100;
   logic        s3_leap_in;
   logic [14:0] s3_sum_in;
   logic [4:0]  s3_day_ff;
   logic [3:0]  s3_month_ff;
   logic [13:0] s3_year_ff;
   logic        s3_leap_ff;
   logic [14:0] s3_sum_ff;

   assign s3_rem100  = s2_year_ff - 14'(s2_cent_y_ff) * 14'd100;
   assign s3_leap_in = ((s2_year_ff[1:0] == 2'd0) && (s3_rem100 != 14'd0))
                    || ((s3_rem100 == 14'd0) && (s2_cent_y_ff[1:0] == 2'd0));

   // Day + year + year/4 - year/100 + year/400 + month term
   assign s3_sum_in = 15'(s2_day_ff) + s2_yy_ff + (s2_yy_ff >> 2)
                    - 15'(s2_cent_yy_ff) + 15'(s2_cent_yy_ff >> 2)
                    + 15'(gdcq_pkg::month_offset(s2_month_ff));

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_day_ff   <= s2_day_ff;
         s3_month_ff <= s2_month_ff;
         s3_year_ff  <= s2_year_ff;
         s3_leap_ff  <= s3_leap_in;
         s3_sum_ff   <= s3_sum_in;
      end
   end

   // ---------------- stage 4: weeks in the sum ----------------
   logic [30:0] s4_prod7;
   logic [11:0] s4_weeks_in;
   logic [4:0]  s4_day_ff;
   logic [3:0]  s4_month_ff;
   logic [13:0] s4_year_ff;
   logic        s4_leap_ff;
   logic [14:0] s4_sum_ff;
   logic [11:0] s4_weeks_ff;

   assign s4_prod7    = 31'(s3_sum_ff) * 31'(gdcq_pkg::RECIP_7);
   assign s4_weeks_in = s4_prod7[gdcq_pkg::SHIFT_7 +: 12];

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_day_ff   <= s3_day_ff;
         s4_month_ff <= s3_month_ff;
         s4_year_ff  <= s3_year_ff;
         s4_leap_ff  <= s3_leap_ff;
         s4_sum_ff   <= s3_sum_ff;
         s4_weeks_ff <= s4_weeks_in;
      end
   end

   // ---------------- stage 5: weekday, calendar rules, result ----------------
   gdcq_pkg::gdcq_date_type rules;
   logic [14:0] wd_full;
   logic [2:0]  wd;
   logic        wk;

   gdcq_date_rules u_rules (
      .day   (s4_day_ff),
      .month (s4_month_ff),
      .year  (s4_year_ff),
      .leap  (s4_leap_ff),
      .rules (rules)
   );

   assign wd_full = s4_sum_ff - 15'(s4_weeks_ff) * 15'd7;
   assign wd      = wd_full[2:0];
   assign wk      = weekend_mask_ff[wd];

   logic [2:0]  weekday_in, days_to_week_end_in;
   logic        end_of_week_in, weekend_flag_in, business_day_in, leap_flag_in;
   logic        date_invalid_in;
   logic [4:0]  days_to_month_end_in, next_day_in;
   logic [8:0]  days_to_year_end_in;
   logic [3:0]  next_month_in;
   logic [13:0] next_year_in;

   // Zero every field of an invalid date but the invalid flag, which is set
   always_comb begin
      date_invalid_in      = !rules.date_valid;
      weekday_in           = 3'd0;
      end_of_week_in       = 1'b0;
      weekend_flag_in      = 1'b0;
      business_day_in      = 1'b0;
      days_to_week_end_in  = 3'd0;
      days_to_month_end_in = 5'd0;
      days_to_year_end_in  = 9'd0;
      next_day_in          = 5'd0;
      next_month_in        = 4'd0;
      next_year_in         = 14'd0;
      leap_flag_in         = 1'b0;
      if (rules.date_valid) begin
         weekday_in           = wd;
         end_of_week_in       = (wd == gdcq_pkg::WD_SATURDAY);
         weekend_flag_in      = wk;
         business_day_in      = !wk;
         days_to_week_end_in  = gdcq_pkg::WD_SATURDAY - wd;
         days_to_month_end_in = rules.days_to_month_end;
         days_to_year_end_in  = rules.days_to_year_end;
         next_day_in          = rules.next_day;
         next_month_in        = rules.next_month;
         next_year_in         = rules.next_year;
         leap_flag_in         = s4_leap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready) begin
         rsp_weekday           <= weekday_in;
         rsp_end_of_week       <= end_of_week_in;
         rsp_weekend_flag      <= weekend_flag_in;
         rsp_business_day      <= business_day_in;
         rsp_days_to_week_end  <= days_to_week_end_in;
         rsp_days_to_month_end <= days_to_month_end_in;
         rsp_days_to_year_end  <= days_to_year_end_in;
         rsp_next_day          <= next_day_in;
         rsp_next_month        <= next_month_in;
         rsp_next_year         <= next_year_in;
         rsp_leap_flag         <= leap_flag_in;
         rsp_date_invalid      <= date_invalid_in;
      end
   end

   // ---------------- checks ----------------
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_invalid |->
         rsp_weekday == 3'd0 && !rsp_leap_flag && !rsp_business_day && rsp_next_day == 5'd0)
      else $error("invalid date gave non-zero result");

   a_week_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_invalid |->
         rsp_weekday <= gdcq_pkg::WD_SATURDAY
         && rsp_days_to_week_end == gdcq_pkg::WD_SATURDAY - rsp_weekday)
      else $error("weekday and days to week end disagree");

   a_business_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_invalid |-> rsp_business_day != rsp_weekend_flag)
      else $error("business day equals weekend flag");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff)
      else $error("blocked item dropped from first stage");

   a_next_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_invalid |->
         rsp_next_day != 5'd0 && rsp_next_month != 4'd0 && rsp_days_to_month_end != 5'd0)
      else $error("following date out of range");

endmodule

`default_nettype wire

// File: test/gregorian_date_calendar_query_tb.sv
// Self-checking testbench for the Gregorian date query block.
`default_nettype none

module gregorian_date_calendar_query_tb;

   localparam int unsigned LATENCY     = 5;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned HOLD_CYCLES = 120;

   // Expected content of one result item
   typedef struct packed {
      logic [2:0]  weekday;
      logic        end_of_week;
      logic        weekend_flag;
      logic        business_day;
      logic [2:0]  days_to_week_end;
      logic [4:0]  days_to_month_end;
      logic [8:0]  days_to_year_end;
      logic [4:0]  next_day;
      logic [3:0]  next_month;
      logic [13:0] next_year;
      logic        leap_flag;
      logic        date_invalid;
   } calendar_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [13:0] req_year = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_weekday;
   logic        rsp_end_of_week;
   logic        rsp_weekend_flag;
   logic        rsp_business_day;
   logic [2:0]  rsp_days_to_week_end;
   logic [4:0]  rsp_days_to_month_end;
   logic [8:0]  rsp_days_to_year_end;
   logic [4:0]  rsp_next_day;
   logic [3:0]  rsp_next_month;
   logic [13:0] rsp_next_year;
   logic        rsp_leap_flag;
   logic        rsp_date_invalid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_weekend_mask = gdcq_pkg::WEEKEND_MASK_RESET;

   // Calendar tables for a common year
   int unsigned common_month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   int unsigned year_day_base [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   calendar_result_type pending_results [$];
   logic [6:0]       mask_shadow = gdcq_pkg::WEEKEND_MASK_RESET;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   logic             hold_request = 1'b0;
   int unsigned      hold_left = 0;
   int unsigned      cycle_count = 0;
   int unsigned      dates_sent = 0;
   int unsigned      results_checked = 0;
   int unsigned      masks_written = 0;
   int unsigned      mismatch_count = 0;

   gregorian_date_calendar_query dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_day               (req_day),
      .req_month             (req_month),
      .req_year              (req_year),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_weekday           (rsp_weekday),
      .rsp_end_of_week       (rsp_end_of_week),
      .rsp_weekend_flag      (rsp_weekend_flag),
      .rsp_business_day      (rsp_business_day),
      .rsp_days_to_week_end  (rsp_days_to_week_end),
      .rsp_days_to_month_end (rsp_days_to_month_end),
      .rsp_days_to_year_end  (rsp_days_to_year_end),
      .rsp_next_day          (rsp_next_day),
      .rsp_next_month        (rsp_next_month),
      .rsp_next_year         (rsp_next_year),
      .rsp_leap_flag         (rsp_leap_flag),
      .rsp_date_invalid      (rsp_date_invalid),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_weekend_mask      (csr_weekend_mask)
   );

   // Generate the clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_leap(input logic [13:0] year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   // Month length, zero for numbers that are not months
   function automatic int unsigned month_days(input logic [3:0] month, input logic [13:0] year);
      if (month < gdcq_pkg::MONTH_JAN || month > gdcq_pkg::MONTH_DEC)
         return 0;
      if (month == gdcq_pkg::MONTH_FEB)
         return is_leap(year) ? 29 : 28;
      return common_month_len[month - 1];
   endfunction

   // Work out every result field of one date under the given weekend mask
   function automatic calendar_result_type predict_calendar(input logic [4:0] day,
         input logic [3:0] month, input logic [13:0] year, input logic [6:0] mask);
      calendar_result_type r;
      int unsigned mlen, shift, yy, mm, wd, doy, ylen;
      logic leap;
      r = '0;
      leap = is_leap(year);
      mlen = month_days(month, year);
      if (mlen == 0 || day == 0 || day > mlen) begin
         r.date_invalid = 1'b1;
         return r;
      end
      // January and February count as months of the year before
      shift = (14 - month) / 12;
      yy = year + 400 - shift;
      mm = month + 12 * shift - 2;
      wd = (day + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      doy = year_day_base[month - 1] + day
          + ((leap && month > gdcq_pkg::MONTH_FEB) ? 1 : 0);
      ylen = leap ? 366 : 365;
      r.weekday = 3'(wd);
      r.end_of_week = (3'(wd) == gdcq_pkg::WD_SATURDAY);
      r.weekend_flag = mask[wd];
      r.business_day = !mask[wd];
      r.days_to_week_end = 3'(6 - wd);
      r.days_to_month_end = 5'(mlen - day + 1);
      r.days_to_year_end = 9'(ylen - doy + 1);
      if (day == mlen) begin
         r.next_day = 5'd1;
         r.next_month = (month == gdcq_pkg::MONTH_DEC) ? gdcq_pkg::MONTH_JAN : month + 4'd1;
         // 14-bit year wraps after 16383
         r.next_year = (month == gdcq_pkg::MONTH_DEC) ? year + 14'd1 : year;
      end else begin
         r.next_day = day + 5'd1;
         r.next_month = month;
         r.next_year = year;
      end
      r.leap_flag = leap;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Track mask writes, predict each accepted date and check each result item
   always @(posedge clock) begin : scoreboard
      calendar_result_type want;
      if (reset) begin
         mask_shadow <= gdcq_pkg::WEEKEND_MASK_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_shadow <= csr_weekend_mask;
            masks_written++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result item with no date outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("end_of_week", want.end_of_week, rsp_end_of_week);
               check_field("weekend_flag", want.weekend_flag, rsp_weekend_flag);
               check_field("business_day", want.business_day, rsp_business_day);
               check_field("days_to_week_end", want.days_to_week_end, rsp_days_to_week_end);
               check_field("days_to_month_end", want.days_to_month_end,
                           rsp_days_to_month_end);
               check_field("days_to_year_end", want.days_to_year_end, rsp_days_to_year_end);
               check_field("next_day", want.next_day, rsp_next_day);
               check_field("next_month", want.next_month, rsp_next_month);
               check_field("next_year", want.next_year, rsp_next_year);
               check_field("leap_flag", want.leap_flag, rsp_leap_flag);
               check_field("date_invalid", want.date_invalid, rsp_date_invalid);
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(predict_calendar(req_day, req_month, req_year,
                                                       mask_shadow));
            dates_sent++;
         end
      end
   end

   // Drive the result stall: random, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_request <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("gregorian_date_calendar_query test failed");
         $finish;
      end
   end

   // Offer one date, idling first at random; valid stays high after acceptance
   task automatic send_date(input logic [4:0] day, input logic [3:0] month,
                            input logic [13:0] year);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_day <= day;
      req_month <= month;
      req_year <= year;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly well-formed dates, biased to month ends and century years
   task automatic send_random_date();
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      int unsigned pick, mlen;
      pick = $urandom_range(99);
      if (pick < 20) begin
         day = 5'($urandom);
         month = 4'($urandom);
         year = 14'($urandom);
      end else begin
         pick = $urandom_range(99);
         if (pick < 10)
            year = 14'(100 * $urandom_range(163));
         else if (pick < 14)
            year = $urandom_range(1) ? 14'd16383 : 14'd0;
         else if (pick < 40)
            year = 14'($urandom);
         else
            year = 14'($urandom_range(9999, 1));
         month = 4'($urandom_range(12, 1));
         mlen = month_days(month, year);
         pick = $urandom_range(99);
         if (pick < 15)
            day = 5'(mlen);
         else if (pick < 25)
            day = 5'd1;
         else
            day = 5'($urandom_range(mlen, 1));
      end
      send_date(day, month, year);
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_weekend_mask(input logic [6:0] mask);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_weekend_mask <= mask;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Field extremes, leap rules, invalid dates and the year wrap
   task automatic test_directed_dates();
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd31, 4'd12, 14'd9999);
      send_date(5'd31, 4'd12, 14'd16383);
      send_date(5'd1, 4'd1, 14'd0);
      send_date(5'd29, 4'd2, 14'd0);
      send_date(5'd29, 4'd2, 14'd2000);
      send_date(5'd29, 4'd2, 14'd1900);
      send_date(5'd28, 4'd2, 14'd1900);
      send_date(5'd29, 4'd2, 14'd2024);
      send_date(5'd1, 4'd3, 14'd2024);
      send_date(5'd0, 4'd5, 14'd2023);
      send_date(5'd31, 4'd4, 14'd2023);
      send_date(5'd31, 4'd1, 14'd2023);
      send_date(5'd15, 4'd0, 14'd2023);
      send_date(5'd15, 4'd13, 14'd2023);
      send_date(5'd31, 4'd15, 14'd16383);
      send_date(5'd30, 4'd12, 14'd2023);
      send_date(5'd1, 4'd1, 14'd2024);
      wait_for_results();
   endtask

   // Empty and full weekend masks over a Saturday, Sunday and Monday
   task automatic test_weekend_mask_extremes();
      write_weekend_mask(7'd0);
      send_date(5'd6, 4'd1, 14'd2024);
      send_date(5'd7, 4'd1, 14'd2024);
      send_date(5'd8, 4'd1, 14'd2024);
      write_weekend_mask(7'd127);
      send_date(5'd6, 4'd1, 14'd2024);
      send_date(5'd7, 4'd1, 14'd2024);
      send_date(5'd8, 4'd1, 14'd2024);
      wait_for_results();
   endtask

   task automatic test_random_dates(input int unsigned send_pct, input int unsigned recv_pct,
                                    input logic [6:0] mask, input int unsigned count);
      write_weekend_mask(mask);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      repeat (count) send_random_date();
      wait_for_results();
   endtask

   // Hold the result side off while dates keep coming, so the input stalls
   task automatic test_result_backpressure();
      int unsigned saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_request <= 1'b1;
      repeat (40) send_random_date();
      send_idle_pct = saved_pct;
      wait_for_results();
   endtask

   initial begin
      send_idle_pct = 32;
      recv_idle_pct <= 86;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_dates();
      test_weekend_mask_extremes();
      test_random_dates(32, 86, 7'($urandom_range(126, 1)), 350);
      test_result_backpressure();
      test_random_dates(86, 32, 7'($urandom_range(126, 1)), 350);
      test_random_dates(0, 0, gdcq_pkg::WEEKEND_MASK_RESET, 350);

      repeat (4 * LATENCY) @(posedge clock);
      $display("%0d dates sent, %0d results checked, %0d mismatches", dates_sent,
               results_checked, mismatch_count);
      $display("weekend mask written %0d times, both extremes and the reset value included",
               masks_written);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("gregorian_date_calendar_query test passed");
      end else begin
         $display("gregorian_date_calendar_query test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/gdcq_pkg.sv
rtl/core/gdcq_date_rules.sv
rtl/core/gregorian_date_calendar_query.sv
test/gregorian_date_calendar_query_tb.sv
